// File: rtl/schema_scalar_value_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef SCHEMA_SCALAR_VALUE_DECODER_MACROS_SVH
`define SCHEMA_SCALAR_VALUE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define SSVD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssvd: same-cycle check failed");
`define SSVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssvd: next-cycle check failed");
`else
`define SSVD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSVD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ssvd_pkg.sv
package ssvd_pkg;

  typedef enum logic [2:0] {
    FN_BOOL   = 3'd0,
    FN_BYTE   = 3'd1,
    FN_INT    = 3'd2,
    FN_UINT   = 3'd3,
    FN_FLOAT  = 3'd4,
    FN_STRING = 3'd5,
    FN_INT64  = 3'd6,
    FN_UINT64 = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    RK_SCALAR = 2'd0,
    RK_UNIT   = 2'd1,
    RK_END    = 2'd2,
    RK_TRUNC  = 2'd3
  } rkind_t;

  typedef struct packed {
    logic [63:0] value_bits;
    rkind_t      result_kind;
    logic        last_of_value;
    logic        exceeds_signed;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t r0;
    result_t r1;
  } push_t;

  localparam int RBUF_DEPTH = 4;
  localparam int RBUF_AW    = 2;
  localparam int RBUF_CW    = 3;

  localparam logic [3:0]  VAR32_LAST_IDX = 4'd5;
  localparam logic [3:0]  VAR64_TAIL_IDX = 4'd8;
  localparam logic [3:0]  FLOAT_BYTES    = 4'd4;
  localparam logic [7:0]  UTF_LEAD2      = 8'hc0;
  localparam logic [7:0]  UTF_LEAD3      = 8'he0;
  localparam logic [7:0]  UTF_LEAD4      = 8'hf0;
  localparam logic [20:0] SUPP_BASE      = 21'h10000;
  localparam logic [15:0] SURR_HI        = 16'hd800;
  localparam logic [15:0] SURR_LO        = 16'hdc00;

endpackage

// File: rtl/ssvd_in_if.sv
interface ssvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [2:0] func;
  logic       at_end;

  modport source (output valid, output data_byte, output func, output at_end, input ready);
  modport sink (input valid, input data_byte, input func, input at_end, output ready);
endinterface

// File: rtl/ssvd_out_if.sv
interface ssvd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic [1:0]  result_kind;
  logic        last_of_value;
  logic        exceeds_signed;

  modport source (output valid, output value_bits, output result_kind, output last_of_value,
                  output exceeds_signed, input ready);
  modport sink (input valid, input value_bits, input result_kind, input last_of_value,
                input exceeds_signed, output ready);
endinterface

// File: rtl/ssvd_step.sv
`include "schema_scalar_value_decoder_macros.svh"

module ssvd_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic [2:0]      func,
  input  logic            at_end,
  output ssvd_pkg::push_t push
);
  import ssvd_pkg::*;

  logic        in_value, in_value_next;
  func_t       active_kind, active_kind_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [7:0]  utf8_lead, utf8_lead_next;
  logic        pair_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value    <= 1'b0;
      active_kind <= FN_BOOL;
      acc         <= '0;
      byte_count  <= '0;
      utf8_lead   <= '0;
    end else begin
      in_value    <= in_value_next;
      active_kind <= active_kind_next;
      acc         <= acc_next;
      byte_count  <= byte_count_next;
      utf8_lead   <= utf8_lead_next;
    end
  end

  always_comb begin
    logic [3:0]  cnt;
    logic [3:0]  cnt_inc;
    logic [63:0] acc0;
    logic [7:0]  lead;
    func_t       kind;
    logic [5:0]  sh7;
    logic [63:0] sh64;
    logic [31:0] v32;
    logic [31:0] z32;
    logic [63:0] v64;
    logic [17:0] acc_u;
    logic [3:0]  need;
    logic        cp_fire;
    logic [20:0] cp;
    logic [20:0] cpo;

    in_value_next    = in_value;
    active_kind_next = active_kind;
    acc_next         = acc;
    byte_count_next  = byte_count;
    utf8_lead_next   = utf8_lead;
    push             = '0;

    cnt     = in_value ? byte_count : 4'd0;
    cnt_inc = cnt + 4'd1;
    acc0    = in_value ? acc : 64'd0;
    lead    = in_value ? utf8_lead : 8'd0;
    kind    = in_value ? active_kind : func_t'(func);
    sh7     = {cnt[2:0], 3'b000} - {3'b000, cnt[2:0]};
    sh64    = {57'd0, data_byte[6:0]} << sh7;
    v32     = '0;
    z32     = '0;
    v64     = '0;
    acc_u   = {acc0[11:0], data_byte[5:0]};
    need    = 4'd1;
    cp_fire = 1'b0;
    cp      = '0;
    cpo     = '0;

    if (accept) begin
      if (at_end) begin
        if (in_value) begin
          in_value_next       = 1'b0;
          acc_next            = '0;
          byte_count_next     = '0;
          utf8_lead_next      = '0;
          push.push0          = 1'b1;
          push.r0.result_kind = RK_TRUNC;
          push.r0.last_of_value = 1'b1;
        end
      end else begin
        in_value_next    = 1'b1;
        active_kind_next = kind;
        acc_next         = acc0;
        byte_count_next  = cnt;
        utf8_lead_next   = lead;
        case (kind)
          FN_BOOL, FN_BYTE: begin
            in_value_next         = 1'b0;
            acc_next              = '0;
            byte_count_next       = '0;
            utf8_lead_next        = '0;
            push.push0            = 1'b1;
            push.r0.result_kind   = RK_SCALAR;
            push.r0.last_of_value = 1'b1;
            push.r0.value_bits    = (kind == FN_BOOL) ? {63'd0, |data_byte}
                                                      : {56'd0, data_byte};
          end
          FN_INT, FN_UINT: begin
            v32      = acc0[31:0] | sh64[31:0];
            acc_next = {32'd0, v32};
            if (!data_byte[7] || cnt >= VAR32_LAST_IDX) begin
              z32                   = v32[0] ? ~(v32 >> 1) : (v32 >> 1);
              in_value_next         = 1'b0;
              acc_next              = '0;
              byte_count_next       = '0;
              push.push0            = 1'b1;
              push.r0.result_kind   = RK_SCALAR;
              push.r0.last_of_value = 1'b1;
              push.r0.value_bits    = (kind == FN_INT) ? {{32{z32[31]}}, z32}
                                                       : {32'd0, v32};
            end else begin
              byte_count_next = cnt_inc;
            end
          end
          FN_FLOAT: begin
            v32 = acc0[31:0] | ({24'd0, data_byte} << {cnt[1:0], 3'b000});
            if (cnt == 4'd0 && data_byte == 8'd0) begin
              in_value_next         = 1'b0;
              acc_next              = '0;
              byte_count_next       = '0;
              push.push0            = 1'b1;
              push.r0.result_kind   = RK_SCALAR;
              push.r0.last_of_value = 1'b1;
            end else if (cnt_inc == FLOAT_BYTES) begin
              in_value_next         = 1'b0;
              acc_next              = '0;
              byte_count_next       = '0;
              push.push0            = 1'b1;
              push.r0.result_kind   = RK_SCALAR;
              push.r0.last_of_value = 1'b1;
              push.r0.value_bits    = {32'd0, v32[8:0], v32[31:9]};
            end else begin
              acc_next        = {32'd0, v32};
              byte_count_next = cnt_inc;
            end
          end
          FN_STRING: begin
            if (lead == 8'd0) begin
              if (data_byte < UTF_LEAD2) begin
                cp_fire = 1'b1;
                cp      = {13'd0, data_byte};
              end else begin
                utf8_lead_next  = data_byte;
                acc_next        = '0;
                byte_count_next = '0;
              end
            end else begin
              if (lead < UTF_LEAD3) begin
                need = 4'd1;
                cp   = {10'd0, lead[4:0], acc_u[5:0]};
              end else if (lead < UTF_LEAD4) begin
                need = 4'd2;
                cp   = {5'd0, lead[3:0], acc_u[11:0]};
              end else begin
                need = 4'd3;
                cp   = {lead[2:0], acc_u};
              end
              if (cnt_inc < need) begin
                acc_next        = {46'd0, acc_u};
                byte_count_next = cnt_inc;
              end else begin
                cp_fire         = 1'b1;
                utf8_lead_next  = '0;
                acc_next        = '0;
                byte_count_next = '0;
              end
            end
          end
          default: begin
            if (cnt < VAR64_TAIL_IDX) begin
              v64 = acc0 | sh64;
            end else begin
              v64 = acc0 | {data_byte, 56'd0};
            end
            if (cnt < VAR64_TAIL_IDX && data_byte[7]) begin
              acc_next        = v64;
              byte_count_next = cnt_inc;
            end else begin
              in_value_next         = 1'b0;
              acc_next              = '0;
              byte_count_next       = '0;
              push.push0            = 1'b1;
              push.r0.result_kind   = RK_SCALAR;
              push.r0.last_of_value = 1'b1;
              if (kind == FN_INT64) begin
                push.r0.value_bits = v64[0] ? ~(v64 >> 1) : (v64 >> 1);
              end else begin
                push.r0.value_bits     = v64;
                push.r0.exceeds_signed = v64[63];
              end
            end
          end
        endcase

        if (cp_fire) begin
          push.push0 = 1'b1;
          if (cp == 21'd0) begin
            in_value_next         = 1'b0;
            acc_next              = '0;
            byte_count_next       = '0;
            utf8_lead_next        = '0;
            push.r0.result_kind   = RK_END;
            push.r0.last_of_value = 1'b1;
          end else if (cp < SUPP_BASE) begin
            push.r0.result_kind = RK_UNIT;
            push.r0.value_bits  = {48'd0, cp[15:0]};
          end else begin
            cpo                 = cp - SUPP_BASE;
            push.push1          = 1'b1;
            push.r0.result_kind = RK_UNIT;
            push.r0.value_bits  = {48'd0, 16'({5'd0, cpo[20:10]} + SURR_HI)};
            push.r1.result_kind = RK_UNIT;
            push.r1.value_bits  = {48'd0, 16'({6'd0, cpo[9:0]} + SURR_LO)};
          end
        end
      end
    end
  end

  assign pair_ok = push.push0 && push.r0.result_kind == RK_UNIT &&
                   push.r1.result_kind == RK_UNIT;

  `SSVD_ASSERT_IMPL(a_pair_units, clk, rst, push.push1, pair_ok)
  `SSVD_ASSERT_NEXT(a_last_goes_idle, clk, rst, push.push0 && push.r0.last_of_value, !in_value)

endmodule

// File: rtl/ssvd_rbuf.sv
`include "schema_scalar_value_decoder_macros.svh"

module ssvd_rbuf (
  input  logic              clk,
  input  logic              rst,
  input  ssvd_pkg::push_t   push,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ssvd_pkg::result_t out_word
);
  import ssvd_pkg::*;

  result_t              mem [RBUF_DEPTH];
  logic [RBUF_AW-1:0]   wr_ptr, rd_ptr;
  logic [RBUF_AW-1:0]   wr_ptr1;
  logic [RBUF_CW-1:0]   count, count_next;
  logic                 pop;

  assign wr_ptr1   = wr_ptr + RBUF_AW'(1);
  assign out_valid = (count != '0);
  assign out_word  = mem[rd_ptr];
  assign pop       = out_valid & out_ready;
  assign in_ready  = (count <= RBUF_CW'(RBUF_DEPTH - 2));
  assign count_next = count + RBUF_CW'(push.push0) + RBUF_CW'(push.push1) - RBUF_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.push1) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push.push1) begin
        wr_ptr <= wr_ptr + RBUF_AW'(2);
      end else if (push.push0) begin
        wr_ptr <= wr_ptr1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RBUF_AW'(1);
      end
    end
  end

  `SSVD_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= RBUF_CW'(RBUF_DEPTH))
  `SSVD_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push.push0, count == $past(count) - RBUF_CW'(1))

endmodule

// File: rtl/schema_scalar_value_decoder.sv
// Channel  Dir  Payload                                                         Handshake
// in_ch    in   data_byte[7:0] func[2:0] at_end                                 valid/ready
// out_ch   out  value_bits[63:0] result_kind[1:0] last_of_value exceeds_signed  valid/ready
//
// One byte word per cycle while in_ch.ready is high; its results are written to a
// 4-entry result buffer at the same clock edge and leave one per cycle while
// out_ch.ready is high, the first on the next cycle. A string byte that closes a
// supplementary code point writes two results. in_ch.ready is high while the result
// buffer has room for two results. rst is synchronous, active high; it returns the
// decoder to idle and empties the buffer.
module schema_scalar_value_decoder (
  input  logic       clk,
  input  logic       rst,
  ssvd_in_if.sink    in_ch,
  ssvd_out_if.source out_ch
);
  import ssvd_pkg::*;

  logic    accept;
  logic    buf_ready;
  push_t   push;
  result_t word;

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid & buf_ready;

  ssvd_step u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .func      (in_ch.func),
    .at_end    (in_ch.at_end),
    .push      (push)
  );

  ssvd_rbuf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_ready  (buf_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (word)
  );

  assign out_ch.value_bits     = word.value_bits;
  assign out_ch.result_kind    = word.result_kind;
  assign out_ch.last_of_value  = word.last_of_value;
  assign out_ch.exceeds_signed = word.exceeds_signed;

endmodule

// File: tb/ssvd_decode_checker.sv
module ssvd_decode_checker (
  input  logic clk,
  input  logic rst,
  ssvd_in_if   in_ch,
  ssvd_out_if  out_ch,
  output int   fail_count,
  output int   pending_count
);
  import ssvd_pkg::*;

  logic        busy;
  func_t       kind;
  logic [63:0] acc;
  logic [3:0]  nbytes;
  logic [7:0]  lead;
  result_t     expected_results[$];
  result_t     want;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic queue_result(input logic [63:0] v, input rkind_t k, input logic exc);
    result_t r;
    r.value_bits     = v;
    r.result_kind    = k;
    r.last_of_value  = (k != RK_UNIT);
    r.exceeds_signed = exc;
    expected_results.push_back(r);
  endtask

  task automatic clear_value();
    busy   = 1'b0;
    acc    = '0;
    nbytes = '0;
    lead   = '0;
  endtask

  task automatic emit_code_point(input logic [31:0] cp);
    logic [31:0] sup;
    logic [31:0] hi_unit;
    logic [31:0] lo_unit;
    if (cp == 0) begin
      clear_value();
      queue_result('0, RK_END, 1'b0);
    end else if (cp < 32'(SUPP_BASE)) begin
      queue_result({48'b0, cp[15:0]}, RK_UNIT, 1'b0);
    end else begin
      sup     = cp - 32'(SUPP_BASE);
      hi_unit = (sup >> 10) + 32'(SURR_HI);
      lo_unit = (sup & 32'h3ff) + 32'(SURR_LO);
      queue_result({48'b0, hi_unit[15:0]}, RK_UNIT, 1'b0);
      queue_result({48'b0, lo_unit[15:0]}, RK_UNIT, 1'b0);
    end
  endtask

  task automatic string_byte(input logic [7:0] b);
    logic [3:0]  need;
    logic [7:0]  mask;
    logic [31:0] cp;
    if (lead == 0) begin
      if (b < UTF_LEAD2) begin
        emit_code_point({24'b0, b});
      end else begin
        lead   = b;
        acc    = '0;
        nbytes = '0;
      end
    end else begin
      acc    = ((acc << 6) | {58'b0, b[5:0]}) & 64'h3ffff;
      nbytes = nbytes + 4'd1;
      if (lead < UTF_LEAD3) begin
        need = 4'd1;
        mask = 8'h1f;
      end else if (lead < UTF_LEAD4) begin
        need = 4'd2;
        mask = 8'h0f;
      end else begin
        need = 4'd3;
        mask = 8'h07;
      end
      if (nbytes >= need) begin
        cp     = ({24'b0, lead & mask} << (6 * need)) | acc[31:0];
        lead   = '0;
        acc    = '0;
        nbytes = '0;
        emit_code_point(cp);
      end
    end
  endtask

  task automatic decode_word(input logic [7:0] b, input logic [2:0] f, input logic e);
    logic [63:0] v;
    logic        more;
    if (e) begin
      if (busy) begin
        clear_value();
        queue_result('0, RK_TRUNC, 1'b0);
      end
    end else begin
      if (!busy) begin
        busy   = 1'b1;
        kind   = func_t'(f);
        acc    = '0;
        nbytes = '0;
        lead   = '0;
      end
      case (kind)
        FN_BOOL: begin
          clear_value();
          queue_result({63'b0, b != 8'h00}, RK_SCALAR, 1'b0);
        end
        FN_BYTE: begin
          clear_value();
          queue_result({56'b0, b}, RK_SCALAR, 1'b0);
        end
        FN_INT, FN_UINT: begin
          acc = (acc | ({57'b0, b[6:0]} << (7 * nbytes))) & 64'hffff_ffff;
          if (!b[7] || nbytes >= VAR32_LAST_IDX) begin
            v = acc;
            if (kind == FN_INT) begin
              v = v[0] ? (~(v >> 1) & 64'hffff_ffff) : (v >> 1);
              if (v[31]) v[63:32] = '1;
            end
            clear_value();
            queue_result(v, RK_SCALAR, 1'b0);
          end else begin
            nbytes = nbytes + 4'd1;
          end
        end
        FN_FLOAT: begin
          if (nbytes == 0 && b == 8'h00) begin
            clear_value();
            queue_result('0, RK_SCALAR, 1'b0);
          end else begin
            acc    = acc | ({56'b0, b} << (8 * nbytes[1:0]));
            nbytes = nbytes + 4'd1;
            if (nbytes == FLOAT_BYTES) begin
              v = {32'b0, acc[8:0], acc[31:9]};
              clear_value();
              queue_result(v, RK_SCALAR, 1'b0);
            end
          end
        end
        FN_STRING: string_byte(b);
        FN_INT64, FN_UINT64: begin
          more = 1'b0;
          if (nbytes < VAR64_TAIL_IDX) begin
            acc = acc | ({57'b0, b[6:0]} << (7 * nbytes));
            if (b[7]) begin
              nbytes = nbytes + 4'd1;
              more   = 1'b1;
            end
          end else begin
            acc = acc | {b, 56'b0};
          end
          if (!more) begin
            v = acc;
            clear_value();
            if (kind == FN_INT64) begin
              v = v[0] ? ~(v >> 1) : (v >> 1);
              queue_result(v, RK_SCALAR, 1'b0);
            end else begin
              queue_result(v, RK_SCALAR, v[63]);
            end
          end
        end
        default: clear_value();
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_value();
      kind = FN_BOOL;
    end else begin
      if (in_ch.valid && in_ch.ready)
        decode_word(in_ch.data_byte, in_ch.func, in_ch.at_end);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: value_bits %h result_kind %0d",
                 out_ch.value_bits, out_ch.result_kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.value_bits !== want.value_bits) begin
            $error("value_bits: expected %h, got %h", want.value_bits, out_ch.value_bits);
            fail_count++;
          end
          if (out_ch.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_ch.result_kind);
            fail_count++;
          end
          if (out_ch.last_of_value !== want.last_of_value) begin
            $error("last_of_value: expected %0b, got %0b", want.last_of_value,
                   out_ch.last_of_value);
            fail_count++;
          end
          if (out_ch.exceeds_signed !== want.exceeds_signed) begin
            $error("exceeds_signed: expected %0b, got %0b", want.exceeds_signed,
                   out_ch.exceeds_signed);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// File: tb/tb_schema_scalar_value_decoder.sv
module tb_schema_scalar_value_decoder;
  import ssvd_pkg::*;

  localparam int RANDOM_WORDS = 1000;
  localparam int CALM_WORDS   = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         cycles = 0;
  int         fail_count;
  int         pending_count;
  int         words_sent = 0;
  int         random_base;
  int         stall_left = 0;
  logic       src_gaps = 1'b1;
  logic       snk_gaps = 1'b1;
  func_t      value_kind;
  logic [7:0] enc_bytes[$];

  ssvd_in_if  in_ch();
  ssvd_out_if out_ch();

  schema_scalar_value_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ssvd_decode_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sink side: random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_left == 0 && snk_gaps && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic [2:0] f, input logic e);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.func      <= f;
    in_ch.at_end    <= e;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    if (!e) words_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  task automatic encode_varint(input int max_len);
    int         len;
    logic [7:0] b;
    len = $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i < len - 1) b[7] = 1'b1;
      else if (len < max_len) b[7] = 1'b0;
      enc_bytes.push_back(b);
    end
  endtask

  task automatic encode_string();
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: enc_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
        4: enc_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
        5: begin
          enc_bytes.push_back(8'($urandom_range(8'hc0, 8'hdf)));
          enc_bytes.push_back(cont_byte());
        end
        6: begin
          enc_bytes.push_back(8'($urandom_range(8'he0, 8'hef)));
          repeat (2) enc_bytes.push_back(cont_byte());
        end
        default: begin
          enc_bytes.push_back(8'($urandom_range(8'hf0, 8'hff)));
          repeat (3) enc_bytes.push_back(cont_byte());
        end
      endcase
    end
    // terminator, plain or overlong
    case ($urandom_range(0, 5))
      3: begin
        enc_bytes.push_back(8'hc0);
        enc_bytes.push_back(8'h80);
      end
      4: begin
        enc_bytes.push_back(8'he0);
        repeat (2) enc_bytes.push_back(8'h80);
      end
      5: begin
        enc_bytes.push_back(8'hf0);
        repeat (3) enc_bytes.push_back(8'h80);
      end
      default: enc_bytes.push_back(8'h00);
    endcase
  endtask

  // sends the encoded value, sometimes cut short by an end-of-buffer word
  task automatic send_encoded(input func_t k);
    int cut;
    cut = enc_bytes.size();
    if ($urandom_range(0, 11) == 0) cut = $urandom_range(0, enc_bytes.size() - 1);
    for (int i = 0; i < cut; i++)
      send_word(enc_bytes[i], (i == 0) ? k : 3'($urandom_range(0, 7)), 1'b0);
    if (cut < enc_bytes.size())
      send_word(8'($urandom), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.func      = '0;
    in_ch.at_end    = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_word(8'h5a, FN_STRING, 1'b1);
    send_word(8'h00, FN_BOOL, 1'b0);
    send_word(8'hff, FN_BYTE, 1'b0);
    // six-byte 32-bit varint, selector changes mid-value
    send_word(8'hff, FN_INT, 1'b0);
    repeat (5) send_word(8'hff, FN_STRING, 1'b0);
    send_word(8'h7f, FN_UINT, 1'b0);
    send_word(8'h00, FN_FLOAT, 1'b0);
    // nine-byte 64-bit varint above the signed max
    send_word(8'hff, FN_UINT64, 1'b0);
    repeat (8) send_word(8'hff, FN_BOOL, 1'b0);
    send_word(8'h01, FN_INT64, 1'b0);
    // stray continuation, code point past 0x10ffff, overlong zero
    send_word(8'h80, FN_STRING, 1'b0);
    send_word(8'hfc, FN_BYTE, 1'b0);
    repeat (3) send_word(8'hbf, FN_BYTE, 1'b0);
    send_word(8'hc0, FN_BYTE, 1'b0);
    send_word(8'h80, FN_BYTE, 1'b0);
    send_word(8'he2, FN_STRING, 1'b0);
    send_word(8'h00, FN_BOOL, 1'b1);

    random_base = words_sent;
    while (words_sent - random_base < RANDOM_WORDS) begin
      if (words_sent - random_base > RANDOM_WORDS - CALM_WORDS) begin
        src_gaps = 1'b0;
        snk_gaps = 1'b0;
      end else if ($urandom_range(0, 24) == 0) begin
        src_gaps = 1'($urandom_range(0, 1));
        snk_gaps = 1'($urandom_range(0, 1));
      end
      value_kind = func_t'($urandom_range(0, 7));
      enc_bytes.delete();
      case (value_kind)
        FN_BOOL, FN_BYTE: enc_bytes.push_back(8'($urandom));
        FN_INT, FN_UINT: encode_varint(6);
        FN_INT64, FN_UINT64: encode_varint(9);
        FN_FLOAT: begin
          if ($urandom_range(0, 5) == 0) enc_bytes.push_back(8'h00);
          else repeat (4) enc_bytes.push_back(8'($urandom));
        end
        default: encode_string();
      endcase
      send_encoded(value_kind);
      if ($urandom_range(0, 19) == 0)
        send_word(8'($urandom), 3'($urandom_range(0, 7)), 1'b1);
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
